// ===== src/svt_pkg.sv =====
// Package for the sorted value table: widths, operation codes and beat types.
package svt_pkg;

  localparam int Depth = 16;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = 5;
  localparam int ValW = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_POP_MIN = 3'd2;
  localparam logic [2:0] OP_POP_MAX = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic signed [ValW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic ok;
    logic signed [ValW-1:0] head_value;
    logic signed [ValW-1:0] tail_value;
    logic [CntW-1:0] count;
  } out_beat_t;

endpackage

// ===== src/svt_ram.sv =====
// Generic single-port-write, one-read RAM with a registered read.
module svt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sorted_value_table.sv =====
// Sorted value table: holds up to Depth signed values in ascending order in one RAM.
// Pop-max, clear, an unused code, a full insert and a remove on an empty table go straight
// to the head and tail fetch; remove scans for the match and shifts later entries down,
// pop-min shifts the entries down (none at one entry), insert moves each larger entry up.
// One beat is in work at a time; the next beat is taken the cycle after the result is
// registered, and a result that has not been taken holds the next one back.
// Reset (rst, synchronous) empties the table; RAM contents are not cleared.
module sorted_value_table
  import svt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // read issued, wait for data
  localparam logic [2:0] S_INS  = 3'd2;  // insert: walk down, shifting up
  localparam logic [2:0] S_FIND = 3'd3;  // remove: scan for the match
  localparam logic [2:0] S_SHD  = 3'd4;  // remove: shift down
  localparam logic [2:0] S_HEAD = 3'd5;  // fetch head for the result
  localparam logic [2:0] S_TAIL = 3'd6;  // fetch tail for the result
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;
  logic [2:0] op;
  logic signed [ValW-1:0] value;
  logic [CntW:0] occ;     // fill level, one bit wider than the result count
  logic [CntW:0] pos;     // position being worked on
  logic ok;
  logic signed [ValW-1:0] head;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [ValW-1:0] wdata, rdata;

  svt_ram #(.Width(ValW), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  logic signed [ValW-1:0] rd_s;
  assign rd_s = signed'(rdata);

  // The read address is the position held in pos, offset in a walk so that reads run ahead of it.
  always_comb begin
    we = 1'b0;
    waddr = pos[IdxW-1:0];
    wdata = rdata;
    raddr = pos[IdxW-1:0];
    case (state)
      S_RD: begin
        // First read of each walk: insert looks at entry pos-1, the match scan
        // starts at entry 0, and pop-min shifts from entry 1.
        case (op)
          OP_INSERT: raddr = pos[IdxW-1:0] - IdxW'(1);
          OP_REMOVE: raddr = pos[IdxW-1:0];
          default:   raddr = pos[IdxW-1:0] + IdxW'(1);
        endcase
      end
      S_INS: begin
        // rdata holds entry pos-1 (pos > 0 here unless handled below).
        if (pos != '0 && rd_s > value) begin
          we = 1'b1;
          waddr = pos[IdxW-1:0];
          wdata = rdata;
        end else begin
          we = 1'b1;
          waddr = pos[IdxW-1:0];
          wdata = value;
        end
        raddr = pos[IdxW-1:0] - IdxW'(2);
      end
      S_SHD: begin
        // rdata holds entry pos+1; write it at pos.
        we = 1'b1;
        waddr = pos[IdxW-1:0];
        wdata = rdata;
        raddr = pos[IdxW-1:0] + IdxW'(2);
      end
      S_FIND: raddr = pos[IdxW-1:0] + IdxW'(1);
      // The head is read first and the tail after it, so the tail data is
      // on rdata while the result waits in S_DONE.
      S_HEAD: raddr = '0;
      S_TAIL: raddr = IdxW'(occ - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= in_data.op;
            value <= in_data.value;
            case (in_data.op)
              OP_INSERT: begin
                if (occ < (CntW+1)'(Depth)) begin
                  ok <= 1'b1;
                  pos <= occ;
                  if (occ == '0) begin
                    state <= S_INS;
                  end else begin
                    state <= S_RD;
                  end
                end else begin
                  ok <= 1'b0;
                  state <= S_HEAD;
                end
              end
              OP_REMOVE: begin
                ok <= 1'b0;
                pos <= '0;
                state <= (occ == '0) ? S_HEAD : S_RD;
              end
              OP_POP_MIN: begin
                pos <= '0;
                if (occ != '0) begin
                  ok <= 1'b1;
                  if (occ == (CntW+1)'(1)) begin
                    occ <= '0;
                    state <= S_HEAD;
                  end else begin
                    state <= S_RD;
                  end
                end else begin
                  ok <= 1'b0;
                  state <= S_HEAD;
                end
              end
              OP_POP_MAX: begin
                if (occ != '0) begin
                  ok <= 1'b1;
                  occ <= occ - 1'b1;
                end else begin
                  ok <= 1'b0;
                end
                state <= S_HEAD;
              end
              OP_CLEAR: begin
                ok <= 1'b1;
                occ <= '0;
                state <= S_HEAD;
              end
              default: begin
                ok <= 1'b0;
                state <= S_HEAD;
              end
            endcase
          end
        end
        S_RD: begin
          // The read of the first entry to look at is in flight.
          case (op)
            OP_INSERT: state <= S_INS;
            OP_REMOVE: state <= S_FIND;
            default: state <= S_SHD;  // pop-min shifts from entry 1
          endcase
        end
        S_INS: begin
          if (pos != '0 && rd_s > value) begin
            pos <= pos - 1'b1;
          end else begin
            occ <= occ + 1'b1;
            state <= S_HEAD;
          end
        end
        S_FIND: begin
          if (rdata == value) begin
            ok <= 1'b1;
            if (pos + 1'b1 >= occ) begin
              occ <= occ - 1'b1;
              state <= S_HEAD;
            end else begin
              state <= S_SHD;
            end
          end else if (pos + 1'b1 >= occ) begin
            state <= S_HEAD;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_SHD: begin
          if (pos + (CntW+1)'(2) >= occ) begin
            occ <= occ - 1'b1;
            state <= S_HEAD;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_HEAD: begin
          pos <= '0;
          state <= S_TAIL;
        end
        S_TAIL: begin
          head <= rd_s;
          pos <= occ - 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data.ok <= ok;
            out_data.count <= occ[CntW-1:0];
            out_data.head_value <= (occ == '0) ? '0 : head;
            out_data.tail_value <= (occ == '0) ? '0 : rd_s;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_sorted_value_table.sv =====
// Testbench for the sorted value table: directed table, random operations, predictor check.
`timescale 1ns / 100ps

module tb_sorted_value_table;
  import svt_pkg::*;

  // Operation codes 5..7 are unused; the block must answer them with ok=0.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int RandomBeats = 900;
  localparam int IdleLimit = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  sorted_value_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // The clock runs at a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: a sorted copy of the table and its fill level.
  logic signed [ValW-1:0] shadow_vals[Depth];
  int shadow_fill = 0;
  out_beat_t expected_results[$];
  int mismatches = 0;
  bit timed_out = 0;
  bit stim_done = 0;
  bit long_hold = 0;
  int idle_cycles = 0;

  // Apply one operation to the shadow table and return the result it should produce.
  function automatic out_beat_t table_update(in_beat_t b);
    out_beat_t r;
    int pos;
    r = '0;
    case (b.op)
      OP_INSERT: begin
        if (shadow_fill < Depth) begin
          // The new value goes after every held value that is not larger.
          pos = shadow_fill;
          while (pos > 0 && shadow_vals[pos-1] > b.value) begin
            shadow_vals[pos] = shadow_vals[pos-1];
            pos--;
          end
          shadow_vals[pos] = b.value;
          shadow_fill++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_vals[i] == b.value) begin
            for (int j = i; j + 1 < shadow_fill; j++) shadow_vals[j] = shadow_vals[j+1];
            shadow_fill--;
            r.ok = 1'b1;
            break;
          end
        end
      end
      OP_POP_MIN: begin
        if (shadow_fill > 0) begin
          for (int j = 0; j + 1 < shadow_fill; j++) shadow_vals[j] = shadow_vals[j+1];
          shadow_fill--;
          r.ok = 1'b1;
        end
      end
      OP_POP_MAX: begin
        if (shadow_fill > 0) begin
          shadow_fill--;
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_fill = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    if (shadow_fill > 0) begin
      r.head_value = shadow_vals[0];
      r.tail_value = shadow_vals[shadow_fill-1];
    end
    r.count = CntW'(shadow_fill);
    return r;
  endfunction

  // Drive one beat at the falling edge after a random gap and wait for acceptance.
  // A hand-typed expectation, when given, is checked against the predictor too.
  task automatic send_beat(input logic [2:0] op, input logic signed [ValW-1:0] value,
                           input bit typed, input out_beat_t typed_res);
    in_beat_t b;
    out_beat_t r;
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    b.op = op;
    b.value = value;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    r = table_update(b);
    if (typed && r !== typed_res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Directed row disagrees with predictor: op %0d typed %p predicted %p",
                 op, typed_res, r);
    end
    expected_results.push_back(typed ? typed_res : r);
    // The beat is taken at the rising edge where valid is high and stall is low.
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Random value: extremes, a small clustered range to force duplicates and
  // matches, a value already held, or a fully random word.
  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4, 5: return ValW'($signed($urandom_range(0, 20)) - 10);
      6: if (shadow_fill > 0) return shadow_vals[$urandom_range(0, shadow_fill-1)];
      default: ;
    endcase
    return $urandom;
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Directed stimulus: extremes, every operation and each corner case.
  typedef struct {
    logic [2:0] op;
    logic signed [ValW-1:0] value;
    bit typed;
    out_beat_t res;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    // Removing from an empty table fails and leaves it empty.
    '{OP_POP_MIN, 0, 1, '{1'b0, 0, 0, 5'd0}},
    '{OP_POP_MAX, 0, 1, '{1'b0, 0, 0, 5'd0}},
    '{OP_REMOVE, 5, 1, '{1'b0, 0, 0, 5'd0}},
    // Clearing an empty table still succeeds.
    '{OP_CLEAR, 0, 1, '{1'b1, 0, 0, 5'd0}},
    '{OP_INSERT, 32'sh7fff_ffff, 1, '{1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff, 5'd1}},
    '{OP_INSERT, 32'sh8000_0000, 1, '{1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 5'd2}},
    '{OP_INSERT, 0, 0, '0},
    '{OP_INSERT, 0, 0, '0},
    '{OP_INSERT, -1, 0, '0},
    // A value that is not held cannot be removed.
    '{OP_REMOVE, 7, 0, '0},
    '{OP_REMOVE, 0, 0, '0},
    '{OP_UNUSED_LO, 3, 0, '0},
    '{OP_UNUSED_MID, -3, 0, '0},
    '{OP_UNUSED_HI, 32'sh5555_aaaa, 0, '0},
    '{OP_POP_MIN, 0, 0, '0},
    '{OP_POP_MAX, 0, 0, '0},
    '{OP_CLEAR, 0, 1, '{1'b1, 0, 0, 5'd0}}
  };

  // Sender: directed rows, a fill past the top, then random operations.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
    // Fill the table, then two more inserts must be dropped. The receiver
    // holds off meanwhile so the block backs up and stalls its input.
    long_hold = 1;
    for (int k = 0; k < Depth + 2; k++) send_beat(OP_INSERT, pick_value(), 0, '0);
    // Pause until every result is back before going on.
    wait_drained();
    for (int k = 0; k < RandomBeats; k++) begin
      logic [2:0] op;
      int pick;
      pick = $urandom_range(0, 99);
      // Lean toward inserts while the table is short, toward removals when full.
      if (pick < (shadow_fill > Depth - 3 ? 25 : 45)) op = OP_INSERT;
      else if (pick < 70) op = OP_REMOVE;
      else if (pick < 82) op = OP_POP_MIN;
      else if (pick < 94) op = OP_POP_MAX;
      else if (pick < 97) op = OP_CLEAR;
      else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      send_beat(op, $urandom_range(0, 15) == 0 ? ValW'($urandom) : pick_value(), 0, '0);
      if (k == RandomBeats / 2) wait_drained();
    end
    stim_done = 1;
  end

  // Receiver stall: a random hold-off before each result, plus one long hold.
  initial begin
    int hold;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
      // Keep stall low until one result is taken or a long hold is asked for.
      do @(posedge clk); while (!(out_valid && !out_stall) && !long_hold);
    end
  end

  // Result checker, sampling at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", out_data);
      end else begin
        out_beat_t e;
        e = expected_results.pop_front();
        if (out_data.ok !== e.ok || out_data.head_value !== e.head_value ||
            out_data.tail_value !== e.tail_value || out_data.count !== e.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Result mismatch: expected ok %0b head %0d tail %0d count %0d,",
                      " got ok %0b head %0d tail %0d count %0d"},
                     e.ok, e.head_value, e.tail_value, e.count,
                     out_data.ok, out_data.head_value, out_data.tail_value, out_data.count);
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted beat on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) timed_out <= 1;
  end

  // End of run: drain, let the block settle, then report once.
  initial begin
    wait (stim_done || timed_out);
    while (expected_results.size() != 0 && !timed_out) @(posedge clk);
    repeat (60) @(posedge clk);
    if (timed_out || expected_results.size() != 0) begin
      $display("Test completed with failures");
    end else if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
